// File: design/sensor_scratchpad_decoder_unit_macros.svh
// Assertion macros for the scratchpad decoder.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SENSOR_SCRATCHPAD_DECODER_UNIT_MACROS_SVH
`define SENSOR_SCRATCHPAD_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ssd_pkg.sv
// Shared types, constants and the CRC-8 byte step for the scratchpad decoder.
// No dependencies; used by every module of the block.
package ssd_pkg;

  // Scratchpad frame layout
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;

  localparam logic [POS_W-1:0] POS_RAW_LO = POS_W'(0);
  localparam logic [POS_W-1:0] POS_RAW_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CONFIG = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CRC    = POS_W'(FRAME_BYTES - 1);

  // Reflected CRC-8 polynomial, LSB first
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Result range in sixteenths of a degree
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned RES_W  = 4;
  localparam logic signed [TEMP_W:0] TEMP_MAX = 13'sd2047;
  localparam logic signed [TEMP_W:0] TEMP_MIN = -13'sd2047;

  // Resolution codes from config byte bits 6..5
  localparam logic [1:0] RES_CODE_9  = 2'd0;
  localparam logic [1:0] RES_CODE_10 = 2'd1;
  localparam logic [1:0] RES_CODE_11 = 2'd2;
  localparam logic [1:0] RES_CODE_12 = 2'd3;
  localparam logic [RES_W-1:0] RES_BASE = RES_W'(9);

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [RES_W-1:0]         res_t;

  // Status of the byte held in the input register
  typedef struct packed {
    logic last;       // byte is the CRC byte of the frame
    logic crc_match;  // running CRC equals this byte
  } frame_status_t;

  // One byte through eight LSB-first CRC-8 steps
  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

// File: design/ssd_frame_tracker.sv
// Frame tracker: byte position, running CRC-8 and the kept raw bytes.
// Depends on ssd_pkg.
module ssd_frame_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  start_i,
  output ssd_pkg::frame_status_t status_o,
  output logic [7:0]            raw_lo_o,
  output logic [7:0]            raw_hi_o,
  output logic [7:0]            cfg_o
);
  import ssd_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       crc_q, crc_d;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       crc_eff;
  logic [7:0]       raw_lo_q, raw_hi_q, cfg_q;

  // Restart position and CRC on a frame start
  assign pos_eff = start_i ? '0 : pos_q;
  assign crc_eff = start_i ? '0 : crc_q;

  assign status_o.last      = (pos_eff == POS_CRC);
  assign status_o.crc_match = (crc_eff == byte_i);

  // Advance the CRC and position, or wrap after the CRC byte
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (step_i) begin
      if (status_o.last) begin
        pos_d = '0;
        crc_d = '0;
      end else begin
        pos_d = pos_eff + POS_W'(1);
        crc_d = crc8_byte(crc_eff, byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // Keep bytes 0, 1 and 4
  always_ff @(posedge clk_i) begin
    if (step_i && (pos_eff == POS_RAW_LO)) begin
      raw_lo_q <= byte_i;
    end
    if (step_i && (pos_eff == POS_RAW_HI)) begin
      raw_hi_q <= byte_i;
    end
    if (step_i && (pos_eff == POS_CONFIG)) begin
      cfg_q <= byte_i;
    end
  end

  assign raw_lo_o = raw_lo_q;
  assign raw_hi_o = raw_hi_q;
  assign cfg_o    = cfg_q;

endmodule

// File: design/ssd_temp_decode.sv
// Temperature decode: raw word to saturated sixteenths, masked to resolution.
// Depends on ssd_pkg.
module ssd_temp_decode (
  input  logic [7:0]           raw_lo_i,
  input  logic [7:0]           raw_hi_i,
  input  logic [7:0]           cfg_i,
  output ssd_pkg::temp_t       temp_o,
  output ssd_pkg::res_t        res_o
);
  import ssd_pkg::*;

  logic [15:0]              raw;
  logic                     neg;
  logic [15:0]              mag;
  logic [3:0]               frac_mask;
  logic signed [TEMP_W-1:0] val;
  logic signed [TEMP_W:0]   val_ext;
  logic signed [TEMP_W:0]   val_signed;
  logic signed [TEMP_W:0]   val_sat;

  assign raw = {raw_hi_i, raw_lo_i};
  assign neg = raw[15];

  // Sign to magnitude; 0x8000 stays as it is
  assign mag = neg ? (~raw + 16'd1) : raw;

  // Keep only the fraction bits the resolution provides
  always_comb begin
    unique case (cfg_i[6:5])
      RES_CODE_9:  frac_mask = 4'h8;
      RES_CODE_10: frac_mask = 4'hC;
      RES_CODE_11: frac_mask = 4'hE;
      RES_CODE_12: frac_mask = 4'hF;
      default:     frac_mask = 4'hF;
    endcase
  end

  assign res_o = RES_BASE + {2'b00, cfg_i[6:5]};

  // Signed integer part times sixteen plus fraction
  assign val        = $signed({mag[11:4], mag[3:0] & frac_mask});
  assign val_ext    = {val[TEMP_W-1], val};
  assign val_signed = neg ? -val_ext : val_ext;

  // Clamp to the symmetric range
  always_comb begin
    priority if (val_signed > TEMP_MAX) begin
      val_sat = TEMP_MAX;
    end else if (val_signed < TEMP_MIN) begin
      val_sat = TEMP_MIN;
    end else begin
      val_sat = val_signed;
    end
  end

  assign temp_o = val_sat[TEMP_W-1:0];

endmodule

// File: design/sensor_scratchpad_decoder_unit.sv
// Top level of the scratchpad decoder: input register, frame tracker, decode, result register.
// Depends on ssd_pkg, ssd_frame_tracker, ssd_temp_decode and the assertion macro header.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | [7:0] data_byte                         | [0] frame_start
//  m_axis   | out | [11:0] temperature_sixteenths, [15:12]  | [0] crc_ok
//           |     |        resolution_bits                  |
//
// One byte per cycle is sustained unless a CRC byte meets a waiting result; a CRC byte goes
// from the input register through CRC compare and decode into the result register, which drives m_axis.
// Reset clears position, CRC, held temperature and both valid flags; the kept raw bytes
// are not reset.
// While a result waits on m_axis, bytes that give no result still pass through the tracker;
// the CRC byte of the next frame waits in the input register until the result is taken.
`include "sensor_scratchpad_decoder_unit_macros.svh"

module sensor_scratchpad_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] temperature_sixteenths, [15:12] resolution_bits
  output logic        m_axis_tuser    // [0] crc_ok
);
  import ssd_pkg::*;

  logic          in_valid_q, in_valid_d;
  logic [7:0]    in_byte_q;
  logic          in_start_q;
  logic          in_take;
  logic          advance;
  logic          out_load;

  frame_status_t status;
  logic [7:0]    raw_lo, raw_hi, cfg_byte;
  temp_t         dec_temp;
  res_t          dec_res;

  logic          m_valid_q, m_valid_d;
  temp_t         m_temp_q;
  res_t          m_res_q;
  logic          m_ok_q;
  temp_t         held_q, held_d;

  // Move the held byte on unless it is a CRC byte blocked by a waiting result
  assign advance  = in_valid_q && (!status.last || !m_valid_q || m_axis_tready);
  assign out_load = advance && status.last;

  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  ssd_frame_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .start_i  (in_start_q),
    .status_o (status),
    .raw_lo_o (raw_lo),
    .raw_hi_o (raw_hi),
    .cfg_o    (cfg_byte)
  );

  ssd_temp_decode u_decode (
    .raw_lo_i (raw_lo),
    .raw_hi_i (raw_hi),
    .cfg_i    (cfg_byte),
    .temp_o   (dec_temp),
    .res_o    (dec_res)
  );

  // Update the held temperature only on a CRC match
  assign held_d = (out_load && status.crc_match) ? dec_temp : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  // Result register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_temp_q <= held_d;
      m_res_q  <= dec_res;
      m_ok_q   <= status.crc_match;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q, m_temp_q};
  assign m_axis_tuser  = m_ok_q;

  // Checks on the block's own logic
  `SSD_ASSERT_NEXT(a_held_tracks_match, out_load && status.crc_match,
                   held_q == m_axis_tdata[11:0], "held temperature not updated on CRC match")
  `SSD_ASSERT_NEXT(a_in_reg_holds, in_valid_q && !advance,
                   in_valid_q && $stable(in_byte_q) && $stable(in_start_q),
                   "blocked byte lost from input register")
  `SSD_ASSERT_SAME(a_no_load_over_result, out_load && m_valid_q, m_axis_tready,
                   "result register overwritten while its result waits")
  `SSD_ASSERT_SAME(a_res_range, m_axis_tvalid,
                   m_axis_tdata[15:12] == 4'd9 || m_axis_tdata[15:12] == 4'd10 ||
                   m_axis_tdata[15:12] == 4'd11 || m_axis_tdata[15:12] == 4'd12,
                   "resolution outside nine to twelve bits")

endmodule
